@@ design/rcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared widths, constants and types of the RAID-Z column map block.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int OFFSET_W    = 63;
    localparam int SIZE_W      = 25;
    localparam int ASIZE_W     = 26;
    localparam int POS_W       = 4;
    localparam int DISK_W      = 4;
    localparam int SHIFT_W     = 5;
    localparam int ND_W        = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int SHIFT_MIN   = 9;
    localparam int SHIFT_MAX   = 17;
    localparam int SWAP_BIT    = 20;
    localparam int ALIGN_UNITS = 2;
    localparam int MAX_COLS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;

    // unit index and unit count never exceed these once the shift is clamped
    localparam int BLK_W   = OFFSET_W - SHIFT_MIN;
    localparam int UNITS_W = SIZE_W - SHIFT_MIN;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(9);
    localparam logic [ND_W-1:0]    DISKS_RESET = ND_W'(4);

    // register index, taken from paddr[2]
    localparam logic REG_SECTOR_SHIFT = 1'b0;
    localparam logic REG_DISK_COUNT   = 1'b1;

    typedef struct packed {
        logic [BLK_W-1:0]   blk;
        logic [UNITS_W-1:0] units;
        logic [SHIFT_W-1:0] sh;
        logic [ND_W-1:0]    nd;
        logic               swap;
        logic               bad;
    } rcm_job_t;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [DISK_W-1:0]   child_disk;
        logic [OFFSET_W-1:0] child_offset;
        logic [SIZE_W-1:0]   column_bytes;
        logic                is_parity;
        logic [ASIZE_W-1:0]  total_asize;
        logic                last_column;
        logic                bad_request;
    } rcm_result_t;

endpackage

@@ design/raidz_column_map.sv @@
// ----------------------------------------------------------------------------
// raidz_column_map
// Single-parity stripe column layout: one request in, one result per column.
// ----------------------------------------------------------------------------
// A request is classified on entry and waits in a two-deep queue; the layout
// engine then takes it and runs two restoring dividers side by side, one
// quotient bit per cycle, so the unit-index division by the disk count sets
// the pace. It then collects the quotients, sets up the columns and emits
// them (disk count columns, fewer for small requests). A request smaller
// than one unit yields one result with bad_request set.
// Results wait in an output register; new requests are taken while the queue
// has room. Configuration (shift at 0x0, disk_count at 0x4) is sampled when a
// request is accepted.
module raidz_column_map
    import rcm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic [OFFSET_W-1:0]   byte_offset,
    input  logic [SIZE_W-1:0]     byte_size,
    output logic                  empty,
    input  logic                  pop,
    output logic [POS_W-1:0]      position,
    output logic [DISK_W-1:0]     child_disk,
    output logic [OFFSET_W-1:0]   child_offset,
    output logic [SIZE_W-1:0]     column_bytes,
    output logic                  is_parity,
    output logic [ASIZE_W-1:0]    total_asize,
    output logic                  last_column,
    output logic                  bad_request
);

    rcm_job_t    fe_job;
    logic        fe_push;
    logic        q_full;
    rcm_job_t    q_job;
    logic        q_valid;
    logic        q_pop;
    rcm_result_t result;

    rcm_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .byte_offset (byte_offset),
        .byte_size   (byte_size),
        .full        (full),
        .job_full    (q_full),
        .job_push    (fe_push),
        .job         (fe_job)
    );

    rcm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .din   (fe_job),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_job),
        .valid (q_valid)
    );

    rcm_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign position     = result.position;
    assign child_disk   = result.child_disk;
    assign child_offset = result.child_offset;
    assign column_bytes = result.column_bytes;
    assign is_parity    = result.is_parity;
    assign total_asize  = result.total_asize;
    assign last_column  = result.last_column;
    assign bad_request  = result.bad_request;

endmodule

@@ design/rcm_front.sv @@
// ----------------------------------------------------------------------------
// rcm_front
// Configuration registers and request intake: clamps the configuration,
// converts the request to units and flags requests smaller than one unit.
// ----------------------------------------------------------------------------
module rcm_front
    import rcm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    input  logic [OFFSET_W-1:0]   byte_offset,
    input  logic [SIZE_W-1:0]     byte_size,
    output logic                  full,
    input  logic                  job_full,
    output logic                  job_push,
    output rcm_job_t              job
);

    logic [SHIFT_W-1:0]  sector_shift_reg;
    logic [ND_W-1:0]     disk_count_reg;
    logic [SHIFT_W-1:0]  sh;
    logic [ND_W-1:0]     nd;
    logic [OFFSET_W-1:0] blk_full;
    logic [SIZE_W-1:0]   units_full;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_shift_reg <= SHIFT_RESET;
            disk_count_reg   <= DISKS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_SECTOR_SHIFT: sector_shift_reg <= pwdata[SHIFT_W-1:0];
                REG_DISK_COUNT:   disk_count_reg   <= pwdata[ND_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SECTOR_SHIFT: prdata = APB_DATA_W'(sector_shift_reg);
            REG_DISK_COUNT:   prdata = APB_DATA_W'(disk_count_reg);
        endcase
    end

    always_comb
    begin
        priority if (int'(sector_shift_reg) < SHIFT_MIN)
            sh = SHIFT_W'(SHIFT_MIN);
        else if (int'(sector_shift_reg) > SHIFT_MAX)
            sh = SHIFT_W'(SHIFT_MAX);
        else
            sh = sector_shift_reg;

        priority if (int'(disk_count_reg) < 2)
            nd = ND_W'(2);
        else if (int'(disk_count_reg) > MAX_COLS)
            nd = ND_W'(MAX_COLS);
        else
            nd = disk_count_reg;
    end

    assign blk_full   = byte_offset >> sh;
    assign units_full = byte_size >> sh;

    always_comb
    begin
        job.blk   = BLK_W'(blk_full);
        job.units = UNITS_W'(units_full);
        job.sh    = sh;
        job.nd    = nd;
        job.swap  = byte_offset[SWAP_BIT];
        job.bad   = (units_full == '0);
    end

    assign full     = job_full;
    assign job_push = push && !job_full;

endmodule

@@ design/rcm_queue.sv @@
// ----------------------------------------------------------------------------
// rcm_queue
// Short register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rcm_queue
    import rcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rcm_job_t din,
    output logic     full,
    input  logic     pop,
    output rcm_job_t dout,
    output logic     valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rcm_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (int'(count_reg) == QUEUE_DEPTH);
    assign valid   = (count_reg != '0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/rcm_div.sv @@
// ----------------------------------------------------------------------------
// rcm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcm_div
    import rcm_pkg::*;
#(
    parameter int N_W = BLK_W,
    parameter int D_W = ND_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient,
    output logic [D_W-1:0] remainder
);

    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [D_W:0]     trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (int'(cnt_reg) == N_W - 1)
                busy_reg <= 1'b0;
        end
    end

    // dividend bits shift out the top while quotient bits shift in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N_W-2:0], fits};
            rem_reg <= fits ? D_W'(trial - {1'b0, div_reg}) : trial[D_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ design/rcm_back.sv @@
// ----------------------------------------------------------------------------
// rcm_back
// Layout engine: divides the request into rows and columns, then emits one
// column per cycle into the output register while that register is free.
// ----------------------------------------------------------------------------
module rcm_back
    import rcm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  rcm_job_t    job,
    output logic        job_pop,
    input  logic        pop,
    output logic        empty,
    output rcm_result_t result
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int SUM_W  = ((COL_W > ND_W) ? COL_W : ND_W) + 1;
    localparam int WIDE_W = BLK_W + SHIFT_MAX;
    localparam int LEN_W  = UNITS_W + 1 + SHIFT_MAX;
    localparam int TOT_W  = UNITS_W + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_EMIT
    } state_t;

    state_t              state_reg;
    rcm_job_t            job_reg;
    logic [ND_W-1:0]     first_reg;
    logic [OFFSET_W-1:0] row_reg;
    logic [OFFSET_W-1:0] row_wrap_reg;
    logic [UNITS_W-1:0]  q_reg;
    logic [ND_W-1:0]     r_reg;
    logic [ND_W-1:0]     bc_reg;
    logic [ND_W-1:0]     acols_reg;
    logic [SIZE_W-1:0]   len_hi_reg;
    logic [SIZE_W-1:0]   len_lo_reg;
    logic [ASIZE_W-1:0]  asize_reg;
    logic [COL_W-1:0]    col_reg;
    logic                out_valid_reg;
    rcm_result_t         res_reg;

    logic                blk_busy;
    logic [BLK_W-1:0]    blk_quo;
    logic [ND_W-1:0]     blk_rem;
    logic                units_busy;
    logic [UNITS_W-1:0]  units_quo;
    logic [ND_W-1:0]     units_rem;

    logic                out_free;
    logic                job_take;
    logic                div_start;
    logic                res_load;
    logic [WIDE_W-1:0]   row_wide;
    logic [OFFSET_W-1:0] row_wrap_next;
    logic [ND_W-1:0]     bc_next;
    logic [ND_W-1:0]     acols_next;
    logic [LEN_W-1:0]    len_hi_wide;
    logic [LEN_W-1:0]    len_lo_wide;
    logic [TOT_W-1:0]    tot_units;
    logic [TOT_W-1:0]    tot_even;
    logic [TOT_W+SHIFT_MAX-1:0] asize_wide;
    logic [COL_W-1:0]    col_eff;
    logic [SUM_W-1:0]    disk_sum;
    logic                wrap;
    rcm_result_t         col_res;
    rcm_result_t         bad_res;

    rcm_div #(
        .N_W (BLK_W),
        .D_W (ND_W)
    ) u_blk_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (job.blk),
        .divisor   (job.nd),
        .busy      (blk_busy),
        .quotient  (blk_quo),
        .remainder (blk_rem)
    );

    rcm_div #(
        .N_W (UNITS_W),
        .D_W (ND_W)
    ) u_units_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (job.units),
        .divisor   (job.nd - 1'b1),
        .busy      (units_busy),
        .quotient  (units_quo),
        .remainder (units_rem)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || pop;
        job_take  = (state_reg == S_IDLE) && job_valid && (!job.bad || out_free);
        div_start = job_take && !job.bad;
        job_pop   = job_take;
        // output register is loaded by a bad request or by an emitted column
        res_load  = (job_take && job.bad) || ((state_reg == S_EMIT) && out_free);

        row_wide = WIDE_W'(blk_quo) << job_reg.sh;

        // column sizes: first bc columns carry one extra unit
        bc_next     = r_reg + ND_W'(r_reg != '0);
        acols_next  = (q_reg == '0) ? bc_next : job_reg.nd;
        len_lo_wide = LEN_W'(q_reg) << job_reg.sh;
        len_hi_wide = (LEN_W'(q_reg) + 1'b1) << job_reg.sh;
        // allocated units = units + q + (r != 0), rounded up to ALIGN_UNITS
        tot_units   = TOT_W'(job_reg.units) + TOT_W'(q_reg) + TOT_W'(r_reg != '0);
        tot_even    = (tot_units + TOT_W'(ALIGN_UNITS - 1)) & ~TOT_W'(ALIGN_UNITS - 1);
        asize_wide  = (TOT_W + SHIFT_MAX)'(tot_even) << job_reg.sh;
        row_wrap_next = row_reg + (OFFSET_W'(1) << job_reg.sh);

        // parity rotation exchanges the placement of columns 0 and 1
        if (job_reg.swap && int'(col_reg) < 2)
            col_eff = col_reg ^ COL_W'(1);
        else
            col_eff = col_reg;
        disk_sum = SUM_W'(first_reg) + SUM_W'(col_eff);
        wrap     = (disk_sum >= SUM_W'(job_reg.nd));

        col_res.position     = POS_W'(col_reg);
        col_res.child_disk   = DISK_W'(wrap ? disk_sum - SUM_W'(job_reg.nd) : disk_sum);
        col_res.child_offset = wrap ? row_wrap_reg : row_reg;
        col_res.column_bytes = (int'(col_reg) < int'(bc_reg)) ? len_hi_reg : len_lo_reg;
        col_res.is_parity    = (col_reg == '0);
        col_res.total_asize  = asize_reg;
        col_res.last_column  = (int'(col_reg) + 1 == int'(acols_reg));
        col_res.bad_request  = 1'b0;

        bad_res             = '0;
        bad_res.last_column = 1'b1;
        bad_res.bad_request = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else
        begin
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        job_reg <= job;
                        if (job.bad)
                            res_reg <= bad_res;
                        else
                            state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!blk_busy && !units_busy)
                    begin
                        first_reg <= blk_rem;
                        row_reg   <= OFFSET_W'(row_wide);
                        q_reg     <= units_quo;
                        r_reg     <= units_rem;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    row_wrap_reg <= row_wrap_next;
                    bc_reg       <= bc_next;
                    acols_reg    <= acols_next;
                    len_hi_reg   <= SIZE_W'(len_hi_wide);
                    len_lo_reg   <= SIZE_W'(len_lo_wide);
                    asize_reg    <= ASIZE_W'(asize_wide);
                    col_reg      <= '0;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        res_reg <= col_res;
                        if (col_res.last_column)
                            state_reg <= S_IDLE;
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    assign empty  = !out_valid_reg;
    assign result = res_reg;

endmodule

@@ design/rcm_checker.sv @@
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks of the column map result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rcm_checker
    import rcm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic [POS_W-1:0]    position,
    input logic [DISK_W-1:0]   child_disk,
    input logic [OFFSET_W-1:0] child_offset,
    input logic [SIZE_W-1:0]   column_bytes,
    input logic                is_parity,
    input logic [ASIZE_W-1:0]  total_asize,
    input logic                last_column,
    input logic                bad_request
);

    // a waiting result stays put until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(position) && $stable(child_offset)
                              && $stable(column_bytes) && $stable(last_column)))
        else $error("result changed while waiting");

    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_request) |-> (last_column && position == '0
                                     && column_bytes == '0 && total_asize == '0
                                     && !is_parity && child_disk == '0))
        else $error("bad request result not clean");

    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !bad_request) |-> (column_bytes != '0 && total_asize[9:0] == '0
                                      && (!is_parity || position == '0)))
        else $error("column size or parity flag wrong");

    // columns of one request come out in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_column) ##1 !empty |->
            (position == $past(position) + 1'b1 && !is_parity))
        else $error("column sequence broken");

endmodule

bind raidz_column_map rcm_checker u_rcm_checker (.*);
